@@ src/extendible_hash_table_defines.svh @@
// ----------------------------------------------------------------------------
// Extendible hash table assertion macros
// Shared property templates on the top-level clock and reset.
// ----------------------------------------------------------------------------
`ifndef EXTENDIBLE_HASH_TABLE_DEFINES_SVH
`define EXTENDIBLE_HASH_TABLE_DEFINES_SVH

// same-cycle implication
`define EHT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EHT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/eht_pkg.sv @@
// ----------------------------------------------------------------------------
// Extendible hash table package
// Sizes, codes and beat types shared by the front, back and top level.
// ----------------------------------------------------------------------------
package eht_pkg;

    localparam int MAX_DEPTH        = 6;
    localparam int SLOTS_PER_BUCKET = 16;
    localparam int NBKT             = 1 << MAX_DEPTH;
    localparam int BKT_W            = MAX_DEPTH;
    localparam int SLOT_W           = $clog2(SLOTS_PER_BUCKET);
    localparam int FILL_W           = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int KADDR_W          = BKT_W + SLOT_W;
    localparam int KEY_W            = 32;
    localparam int GD_W             = 3;
    localparam int OVF_W            = BKT_W + 1;
    localparam int CAP_W            = 5;
    localparam int CMP_W            = (CAP_W > FILL_W) ? CAP_W : FILL_W;
    localparam int INIT_DEPTH_RST   = 1;
    localparam int CAP_RST          = 4;

    typedef enum logic [1:0] {
        OP_INS  = 2'd0,
        OP_SRCH = 2'd1,
        OP_DEL  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_INSERTED   = 3'd0,
        ST_DUPLICATE  = 3'd1,
        ST_FOUND      = 3'd2,
        ST_ABSENT     = 3'd3,
        ST_DELETED    = 3'd4,
        ST_DEL_ABSENT = 3'd5,
        ST_FULL       = 3'd6
    } t_status;

    typedef struct packed {
        logic [1:0]              opcode;
        logic signed [KEY_W-1:0] key;
    } t_cmd;

    typedef struct packed {
        t_status         status;
        logic [BKT_W-1:0] bucket;
        logic [GD_W-1:0]  depth_now;
    } t_result;

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
    } t_item;

    function automatic logic [GD_W-1:0] sat_depth(input logic [GD_W-1:0] d);
        return (d > GD_W'(MAX_DEPTH)) ? GD_W'(MAX_DEPTH) : d;
    endfunction

    function automatic logic [BKT_W-1:0] depth_mask(input logic [GD_W-1:0] d);
        return (BKT_W'(1) << d) - BKT_W'(1);
    endfunction

endpackage

@@ src/extendible_hash_table.sv @@
// A command is taken from the queue, its fill count read and the n keys in the
// addressed bucket (max 16) scanned before the o_done beat; a delete that finds its key
// then shifts the bucket tail down. A directory doubling rehashes every old bucket i.
// The back end takes one command at a time, its scan set by the single read port of the
// key store; a 2-deep queue holds waiting beats.
// Reset or a register write (via r_clr) empties the table; results are never stalled.
// ----------------------------------------------------------------------------
// Extendible hash table
// Integer-key hash table with directory doubling, APB register port.
// ----------------------------------------------------------------------------
`include "extendible_hash_table_defines.svh"

module extendible_hash_table import eht_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_cmd        i_cmd,
    output logic        o_done,
    output t_result     o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [GD_W-1:0]  r_init_depth;
    logic [CAP_W-1:0] r_cap;
    logic             r_clr;
    logic             cfg_wr;
    logic             q_valid;
    t_item            q_item;
    logic             q_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? 32'(r_cap) : 32'(r_init_depth);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_depth <= GD_W'(INIT_DEPTH_RST);
            r_cap        <= CAP_W'(CAP_RST);
            r_clr        <= 1'b0;
        end else begin
            r_clr <= cfg_wr;
            if (cfg_wr) begin
                if (paddr[2]) begin
                    r_cap <= pwdata[CAP_W-1:0];
                end else begin
                    r_init_depth <= pwdata[GD_W-1:0];
                end
            end
        end
    end

    eht_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_cmd     (i_cmd),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    eht_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clr        (r_clr),
        .i_init_depth (r_init_depth),
        .i_cap        (r_cap),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_q_pop      (q_pop),
        .o_done       (o_done),
        .o_result     (o_result)
    );

    `EHT_ASSERT_NXT(a_done_gap, o_done, !o_done, "back-to-back result beats")
    `EHT_ASSERT_IMP(a_depth_max, o_done, o_result.depth_now <= GD_W'(MAX_DEPTH), "depth big")
    `EHT_ASSERT_IMP(a_bkt_fit, o_done, (o_result.bucket >> o_result.depth_now) == '0, "bucket wide")

endmodule

@@ src/eht_front.sv @@
// ----------------------------------------------------------------------------
// Extendible hash table front end
// Takes command beats, decodes the opcode and queues items for the back end.
// ----------------------------------------------------------------------------
module eht_front import eht_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_cmd  i_cmd,
    output logic  o_q_valid,
    output t_item o_q_item,
    input  logic  i_q_pop
);

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_item      dec;

    always_comb begin
        dec.key = i_cmd.key;
        unique case (i_cmd.opcode)
            2'(OP_INS): dec.op = OP_INS;
            2'(OP_DEL): dec.op = OP_DEL;
            default:    dec.op = OP_SRCH;   // unused opcode searches
        endcase
    end

    assign busy      = (r_cnt == 2'd2);
    assign push      = start && !busy;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

endmodule

@@ src/eht_back.sv @@
// ----------------------------------------------------------------------------
// Extendible hash table back end
// Sequencer over the key store and fill counts: scan, insert, delete, split.
// ----------------------------------------------------------------------------
module eht_back import eht_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clr,
    input  logic [GD_W-1:0]  i_init_depth,
    input  logic [CAP_W-1:0] i_cap,
    input  logic             i_q_valid,
    input  t_item            i_q_item,
    output logic             o_q_pop,
    output logic             o_done,
    output t_result          o_result
);

    typedef enum logic [3:0] {
        S_IDLE, S_FILL, S_SCAN, S_DECIDE, S_DSHIFT,
        S_SP_RD, S_SP_N, S_SP_MV, S_SP_W1, S_SP_W2, S_OUT
    } t_state;

    // key store and fill counts
    logic [KEY_W-1:0]  key_mem  [NBKT*SLOTS_PER_BUCKET];
    logic [FILL_W-1:0] fill_mem [NBKT];
    logic [NBKT-1:0]   r_fvalid;
    logic [KEY_W-1:0]  r_kdata;
    logic [FILL_W-1:0] r_fdata;
    logic              r_fdv;

    logic [KADDR_W-1:0] k_raddr, k_waddr;
    logic               k_we;
    logic [KEY_W-1:0]   k_wdata;
    logic [BKT_W-1:0]   f_raddr, f_waddr;
    logic               f_we;
    logic [FILL_W-1:0]  f_wdata;

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [BKT_W-1:0]  r_bkt, n_bkt;
    logic [FILL_W-1:0] r_n, n_n;
    logic [FILL_W-1:0] r_iss, n_iss;
    logic              r_rv, n_rv;
    logic [SLOT_W-1:0] r_ridx, n_ridx;
    logic              r_found, n_found;
    t_status           r_status, n_status;
    logic [GD_W-1:0]   r_gd, n_gd;
    logic [OVF_W-1:0]  r_ovf, n_ovf;
    logic [GD_W-1:0]   r_sd, n_sd;
    logic [BKT_W-1:0]  r_i, n_i;
    logic [FILL_W-1:0] r_lo, n_lo;
    logic [FILL_W-1:0] r_hi, n_hi;
    logic [OVF_W-1:0]  r_over, n_over;
    logic              r_done, n_done;
    t_result           r_res, n_res;

    logic [FILL_W-1:0] fill_val;
    logic [CAP_W-1:0]  cap;
    logic              hit;
    logic [BKT_W-1:0]  hibit;
    logic [BKT_W-1:0]  q_bkt;

    assign fill_val = r_fdv ? r_fdata : '0;
    assign cap      = (i_cap == '0) ? CAP_W'(1) : i_cap;
    assign hit      = r_rv && (r_kdata == r_key);
    assign hibit    = BKT_W'(1) << r_sd;
    assign q_bkt    = i_q_item.key[BKT_W-1:0] & depth_mask(r_gd);
    assign o_done   = r_done;
    assign o_result = r_res;

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_key    = r_key;
        n_bkt    = r_bkt;
        n_n      = r_n;
        n_iss    = r_iss;
        n_rv     = r_rv;
        n_ridx   = r_ridx;
        n_found  = r_found;
        n_status = r_status;
        n_gd     = r_gd;
        n_ovf    = r_ovf;
        n_sd     = r_sd;
        n_i      = r_i;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_over   = r_over;
        n_done   = 1'b0;
        n_res    = r_res;
        o_q_pop  = 1'b0;
        k_raddr  = {r_bkt, r_iss[SLOT_W-1:0]};
        k_we     = 1'b0;
        k_waddr  = {r_bkt, r_n[SLOT_W-1:0]};
        k_wdata  = r_key;
        f_raddr  = r_bkt;
        f_we     = 1'b0;
        f_waddr  = r_bkt;
        f_wdata  = r_n + FILL_W'(1);

        if (i_clr) begin
            n_state = S_IDLE;
            n_gd    = sat_depth(i_init_depth);
            n_ovf   = '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        o_q_pop = 1'b1;
                        n_op    = i_q_item.op;
                        n_key   = i_q_item.key;
                        n_bkt   = q_bkt;
                        f_raddr = q_bkt;
                        n_state = S_FILL;
                    end
                end
                S_FILL: begin
                    n_n     = fill_val;
                    n_iss   = '0;
                    n_rv    = 1'b0;
                    n_state = S_SCAN;
                end
                S_SCAN: begin
                    // one slot read per cycle; the compare uses the registered read data r_kdata
                    if (hit) begin
                        n_found = 1'b1;
                        n_rv    = 1'b0;
                        n_state = S_DECIDE;
                    end else if (r_iss < r_n) begin
                        n_rv   = 1'b1;
                        n_ridx = r_iss[SLOT_W-1:0];
                        n_iss  = r_iss + FILL_W'(1);
                    end else begin
                        n_found = 1'b0;
                        n_rv    = 1'b0;
                        n_state = S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    n_state = S_OUT;
                    unique case (r_op)
                        OP_INS: begin
                            if (r_found) begin
                                n_status = ST_DUPLICATE;
                            end else if (r_n >= FILL_W'(SLOTS_PER_BUCKET)) begin
                                n_status = ST_FULL;
                            end else if (CMP_W'(r_n) != CMP_W'(cap)) begin
                                k_we     = 1'b1;
                                f_we     = 1'b1;
                                n_status = ST_INSERTED;
                            end else if (r_ovf + OVF_W'(1) == (OVF_W'(1) << r_gd)) begin
                                if (r_gd >= GD_W'(MAX_DEPTH)) begin
                                    n_status = ST_FULL;
                                end else begin
                                    k_we     = 1'b1;
                                    f_we     = 1'b1;
                                    n_status = ST_INSERTED;
                                    n_sd     = r_gd;
                                    n_gd     = r_gd + GD_W'(1);
                                    n_i      = '0;
                                    n_over   = '0;
                                    n_state  = S_SP_RD;
                                end
                            end else begin
                                k_we     = 1'b1;
                                f_we     = 1'b1;
                                n_ovf    = r_ovf + OVF_W'(1);
                                n_status = ST_INSERTED;
                            end
                        end
                        OP_DEL: begin
                            if (!r_found) begin
                                n_status = ST_DEL_ABSENT;
                            end else begin
                                n_iss   = FILL_W'(r_ridx) + FILL_W'(1);
                                n_rv    = 1'b0;
                                n_state = S_DSHIFT;
                            end
                        end
                        default: begin
                            n_status = r_found ? ST_FOUND : ST_ABSENT;
                        end
                    endcase
                end
                S_DSHIFT: begin
                    // slide the tail of the bucket down by one slot
                    if (r_rv) begin
                        k_we    = 1'b1;
                        k_waddr = {r_bkt, r_ridx - SLOT_W'(1)};
                        k_wdata = r_kdata;
                    end
                    if (r_iss < r_n) begin
                        n_rv   = 1'b1;
                        n_ridx = r_iss[SLOT_W-1:0];
                        n_iss  = r_iss + FILL_W'(1);
                    end else begin
                        n_rv = 1'b0;
                        if (!r_rv) begin
                            f_we     = 1'b1;
                            f_wdata  = r_n - FILL_W'(1);
                            n_status = ST_DELETED;
                            n_state  = S_OUT;
                        end
                    end
                end
                S_SP_RD: begin
                    f_raddr = r_i;
                    n_state = S_SP_N;
                end
                S_SP_N: begin
                    n_n     = fill_val;
                    n_iss   = '0;
                    n_rv    = 1'b0;
                    n_lo    = '0;
                    n_hi    = '0;
                    n_state = S_SP_MV;
                end
                S_SP_MV: begin
                    // in-place rehash: low writes never pass the read pointer
                    k_raddr = {r_i, r_iss[SLOT_W-1:0]};
                    if (r_rv) begin
                        k_we    = 1'b1;
                        k_wdata = r_kdata;
                        if (r_kdata[r_sd]) begin
                            k_waddr = {r_i | hibit, r_hi[SLOT_W-1:0]};
                            n_hi    = r_hi + FILL_W'(1);
                        end else begin
                            k_waddr = {r_i, r_lo[SLOT_W-1:0]};
                            n_lo    = r_lo + FILL_W'(1);
                        end
                    end
                    if (r_iss < r_n) begin
                        n_rv  = 1'b1;
                        n_iss = r_iss + FILL_W'(1);
                    end else begin
                        n_rv = 1'b0;
                        if (!r_rv) begin
                            n_state = S_SP_W1;
                        end
                    end
                end
                S_SP_W1: begin
                    f_we    = 1'b1;
                    f_waddr = r_i;
                    f_wdata = r_lo;
                    n_over  = r_over + OVF_W'(CMP_W'(r_lo) > CMP_W'(cap));
                    n_state = S_SP_W2;
                end
                S_SP_W2: begin
                    f_we    = 1'b1;
                    f_waddr = r_i | hibit;
                    f_wdata = r_hi;
                    n_over  = r_over + OVF_W'(CMP_W'(r_hi) > CMP_W'(cap));
                    if (r_i == depth_mask(r_sd)) begin
                        n_ovf   = n_over;
                        n_state = S_OUT;
                    end else begin
                        n_i     = r_i + BKT_W'(1);
                        n_state = S_SP_RD;
                    end
                end
                S_OUT: begin
                    n_done            = 1'b1;
                    n_res.status      = r_status;
                    n_res.bucket      = r_key[BKT_W-1:0] & depth_mask(r_gd);
                    n_res.depth_now   = r_gd;
                    n_state           = S_IDLE;
                end
                default: n_state = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (k_we) begin
            key_mem[k_waddr] <= k_wdata;
        end
        r_kdata <= key_mem[k_raddr];
        if (f_we) begin
            fill_mem[f_waddr] <= f_wdata;
        end
        r_fdata <= fill_mem[f_raddr];
        r_fdv   <= r_fvalid[f_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_gd     <= sat_depth(GD_W'(INIT_DEPTH_RST));
            r_ovf    <= '0;
            r_fvalid <= '0;
            r_done   <= 1'b0;
            r_rv     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_gd    <= n_gd;
            r_ovf   <= n_ovf;
            r_done  <= n_done;
            r_rv    <= n_rv;
            if (i_clr) begin
                r_fvalid <= '0;
            end else if (f_we) begin
                r_fvalid[f_waddr] <= 1'b1;
            end
        end
        r_op     <= n_op;
        r_key    <= n_key;
        r_bkt    <= n_bkt;
        r_n      <= n_n;
        r_iss    <= n_iss;
        r_ridx   <= n_ridx;
        r_found  <= n_found;
        r_status <= n_status;
        r_sd     <= n_sd;
        r_i      <= n_i;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_over   <= n_over;
        r_res    <= n_res;
    end

endmodule
